[src/gwwl_pkg.sv]
// Package for the greedy word wrap layout block: field widths, character
// codes, register indexes, sequencer states, the saturating add
// and the word-break test. Depends on nothing; the top level imports it.
`timescale 1ns / 1ps

package gwwl_pkg;

   localparam int CoordW = 16;
   localparam int IndexW = 12;
   localparam int GlyphW = 8;
   localparam int AvailW = 12;
   localparam int LineW  = 8;
   localparam int EntryW = IndexW + 2 * GlyphW;

   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharPeriod  = 8'h2E;
   localparam logic [7:0] CharComma   = 8'h2C;
   localparam logic [7:0] CharQuery   = 8'h3F;

   localparam logic CsrAvailWidth = 1'b0;
   localparam logic CsrLineHeight = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_LINE,
      S_READ,
      S_MOVED,
      S_CUR,
      S_NEWLINE
   } state_type;

   function automatic logic [CoordW-1:0] sat_add(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
      logic [CoordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CoordW] ? {CoordW{1'b1}} : s[CoordW-1:0];
   endfunction

   function automatic logic breaks_word(input logic [7:0] c);
      return (c == CharSpace) || (c == CharPeriod) || (c == CharComma) ||
             (c == CharQuery);
   endfunction

endpackage

[src/gwwl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used as the word buffer; depends on nothing.
`timescale 1ns / 1ps

module gwwl_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/greedy_word_wrap_layout.sv]
// Top level of the greedy word wrap layout block: sequencer, pen state and
// the shared saturating adder. Uses gwwl_pkg and the word buffer gwwl_ram.
`timescale 1ns / 1ps

// Usage:
// Characters arrive on the req_ stream, one beat each: char_code, glyph
// width and height in tdata, the start-of-text flag in tuser. Placements
// leave on the rsp_ stream, one beat per glyph: moved beats of a wrapped
// word first (tuser high), then the current character with tlast high.
// Registers available_width (index 0) and line_height (index 1) are
// written on the csr_ channel, which is always ready; write them only
// while no character is in flight.
// Sequencing: one shared 16-bit saturating adder does every coordinate
// sum, so a plain character passes through accept, evaluate and place
// states, and its beat is registered as it leaves place; a newline is the same.
// A wrap adds a line advance state and, for each moved character, a
// buffer read state and then a place state.
// req_tready is high only between characters. The result register lets the
// next character be accepted while the last beat still waits; when the
// receiver stalls the sequencer holds at its next placement. Reset clears
// the pen, the index, the word and the registers to 640 and 16.

module greedy_word_wrap_layout
   import gwwl_pkg::*;
#(
   parameter int MAX_WORD = 32,
   parameter int MAX_TEXT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], glyph_width[15:8], glyph_height[23:16]
   input  logic        req_tuser,   // start_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // char_index[11:0], place_x[27:12], place_y[43:28], place_w[51:44],
   // place_h[59:52], zero fill[63:60]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // was_moved
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);

   localparam int AW = $clog2(MAX_WORD);
   localparam int CW = $clog2(MAX_WORD + 1);
   localparam logic [CW-1:0] MaxWord = CW'(MAX_WORD);
   localparam logic [16:0]   MaxText = 17'(MAX_TEXT);

   state_type state_ff, state_in;

   logic [AvailW-1:0] avail_ff;
   logic [LineW-1:0]  line_h_ff;

   logic [CoordW-1:0] pen_x_ff, pen_y_ff, word_start_ff, x_ff;
   logic [IndexW-1:0] next_index_ff, idx_ff;
   logic [CW-1:0]     count_ff, k_ff;
   logic              too_long_ff;

   logic              start_ff;
   logic [7:0]        char_ff;
   logic [GlyphW-1:0] w_ff, h_ff;

   logic              rsp_valid_ff;
   logic [63:0]       rsp_data_ff;
   logic              rsp_moved_ff, rsp_last_ff;

   // Shared adder operands and result.
   logic [CoordW-1:0] add_a, add_b, add_sum;
   logic [CoordW:0]   add_raw;

   logic              req_accept, out_free, out_load;
   logic              ram_we, ram_re;
   logic [EntryW-1:0] ram_rdata;
   logic [GlyphW-1:0] rd_w, rd_h;
   logic [IndexW-1:0] rd_index;

   logic              is_nl, store_ok, do_wrap;
   logic [CoordW-1:0] word_start_eff;
   logic [IndexW:0]   idx_inc;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_nl      = (char_ff == CharNewline);
   assign store_ok   = !too_long_ff && (count_ff < MaxWord);
   assign {rd_h, rd_w, rd_index} = ram_rdata;

   assign word_start_eff = (count_ff == '0 && !too_long_ff) ? pen_x_ff : word_start_ff;
   assign add_raw = {1'b0, add_a} + {1'b0, add_b};
   assign add_sum = sat_add(add_a, add_b);
   assign do_wrap = (add_raw > {5'b0, avail_ff}) && (word_start_eff != '0) && store_ok;

   assign idx_inc = {1'b0, next_index_ff} + 1'b1;

   gwwl_ram #(
      .WIDTH (EntryW),
      .DEPTH (MAX_WORD)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({h_ff, w_ff, idx_ff}),
      .rd_en   (ram_re),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (is_nl) begin
               state_in = S_NEWLINE;
            end else if (do_wrap) begin
               state_in = S_LINE;
            end else begin
               state_in = S_CUR;
            end
         end
         S_LINE: begin
            state_in = (count_ff == '0) ? S_CUR : S_READ;
         end
         S_READ: begin
            state_in = S_MOVED;
         end
         S_MOVED: begin
            if (out_free) begin
               state_in = (k_ff + 1'b1 < count_ff) ? S_READ : S_CUR;
            end
         end
         S_CUR, S_NEWLINE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake, buffer strobes and adder operands.
   always_comb begin
      req_tready = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      out_load   = 1'b0;
      add_a      = '0;
      add_b      = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_EVAL: begin
            if (is_nl) begin
               add_a = pen_y_ff;
               add_b = CoordW'(line_h_ff);
            end else begin
               add_a = pen_x_ff;
               add_b = CoordW'(w_ff);
            end
         end
         S_LINE: begin
            add_a = pen_y_ff;
            add_b = CoordW'(line_h_ff);
         end
         S_READ: begin
            ram_re = 1'b1;
         end
         S_MOVED: begin
            out_load = out_free;
            add_a    = x_ff;
            add_b    = CoordW'(rd_w);
         end
         S_CUR: begin
            out_load = out_free;
            ram_we   = out_free && store_ok;
            add_a    = x_ff;
            add_b    = CoordW'(w_ff);
         end
         S_NEWLINE: begin
            out_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         avail_ff      <= AvailW'(640);
         line_h_ff     <= LineW'(16);
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         word_start_ff <= '0;
         next_index_ff <= '0;
         count_ff      <= '0;
         too_long_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrAvailWidth: avail_ff  <= csr_data;
               CsrLineHeight: line_h_ff <= csr_data[LineW-1:0];
               default:       avail_ff  <= avail_ff;
            endcase
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept && req_tuser) begin
                  pen_x_ff      <= '0;
                  pen_y_ff      <= '0;
                  word_start_ff <= '0;
                  next_index_ff <= '0;
                  count_ff      <= '0;
                  too_long_ff   <= 1'b0;
               end
            end
            S_EVAL: begin
               // A count of MAX_TEXT folds back to zero; the 12-bit field
               // wraps on its own for larger texts.
               next_index_ff <= (17'(idx_inc) == MaxText) ? '0 : idx_inc[IndexW-1:0];
               if (is_nl) begin
                  pen_x_ff    <= '0;
                  pen_y_ff    <= add_sum;
                  count_ff    <= '0;
                  too_long_ff <= 1'b0;
               end else begin
                  word_start_ff <= word_start_eff;
                  x_ff          <= do_wrap ? '0 : pen_x_ff;
               end
            end
            S_LINE: begin
               pen_y_ff      <= add_sum;
               word_start_ff <= '0;
            end
            S_MOVED: begin
               if (out_free) begin
                  x_ff <= add_sum;
               end
            end
            S_CUR: begin
               if (out_free) begin
                  pen_x_ff <= add_sum;
                  if (breaks_word(char_ff)) begin
                     count_ff    <= '0;
                     too_long_ff <= 1'b0;
                  end else if (store_ok) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     too_long_ff <= 1'b1;
                  end
               end
            end
            default: begin
               pen_x_ff <= pen_x_ff;
            end
         endcase
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         start_ff <= req_tuser;
         char_ff  <= req_tdata[7:0];
         w_ff     <= req_tdata[15:8];
         h_ff     <= req_tdata[23:16];
      end
      if (state_ff == S_EVAL) begin
         idx_ff <= next_index_ff;
      end
      if (state_ff == S_LINE) begin
         k_ff <= '0;
      end else if (state_ff == S_MOVED && out_free) begin
         k_ff <= k_ff + 1'b1;
      end
      if (out_load) begin
         case (state_ff)
            S_MOVED: begin
               rsp_data_ff  <= {4'b0, rd_h, rd_w, pen_y_ff, x_ff, rd_index};
               rsp_moved_ff <= 1'b1;
               rsp_last_ff  <= 1'b0;
            end
            S_CUR: begin
               rsp_data_ff  <= {4'b0, h_ff, w_ff, pen_y_ff, x_ff, idx_ff};
               rsp_moved_ff <= 1'b0;
               rsp_last_ff  <= 1'b1;
            end
            default: begin
               rsp_data_ff  <= {4'b0, {2 * GlyphW{1'b0}}, pen_y_ff, {CoordW{1'b0}},
                                idx_ff};
               rsp_moved_ff <= 1'b0;
               rsp_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_moved_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   // The start flag is consumed at accept; keep it visible for the checks.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && start_ff) |-> (count_ff == '0 && pen_x_ff == '0))
      else $error("start of text did not clear the word and pen");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxWord)
      else $error("word count beyond buffer depth");

   a_too_long_full: assert property (@(posedge clock) disable iff (reset)
      too_long_ff |-> (count_ff == MaxWord))
      else $error("overlong word flag set with a buffer that is not full");

   a_moved_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("moved beat marked as last of run");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EVAL && !req_tready))
      else $error("accepted character not evaluated next cycle");

endmodule

[tb/sv/tb_greedy_word_wrap_layout.sv]
// Self-checking testbench for greedy_word_wrap_layout: predicts every glyph
// placement, including the replay of a wrapped word, and checks each rsp beat.
// Depends on gwwl_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_greedy_word_wrap_layout;
   import gwwl_pkg::*;

   localparam int WordSlots   = 32;
   localparam int SettleTicks = 8;
   localparam int CycleLimit  = 8_000_000;
   localparam int ShownErrors = 10;

   localparam logic [7:0] CharLowest  = 8'h00;
   localparam logic [7:0] CharHighest = 8'hFF;
   localparam logic [7:0] CharLetterA = 8'h61;

   typedef struct packed {
      logic       start;
      logic [7:0] code;
      logic [7:0] gw;
      logic [7:0] gh;
   } glyph_type;

   typedef struct packed {
      logic [11:0] index;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic        moved;
      logic        last;
   } placement_type;

   typedef struct packed {
      logic [11:0] index;
      logic [7:0]  w;
      logic [7:0]  h;
   } word_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // char_code[7:0], glyph_width[15:8], glyph_height[23:16]
   logic        req_tuser = 1'b0; // start_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // char_index[11:0], place_x[27:12], place_y[43:28], place_w[51:44],
   // place_h[59:52], zero fill[63:60]
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;        // was_moved
   logic        rsp_tlast;        // last_of_run
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [11:0] csr_data = '0;

   greedy_word_wrap_layout i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Layout state kept by the testbench.
   logic [11:0] avail_width = 12'd640;
   logic [7:0]  row_step = 8'd16;
   logic [15:0] pen_x, pen_y, word_x0;
   logic [11:0] text_index;
   logic [5:0]  word_len;
   logic        word_overflow;
   word_slot_type word_buf [WordSlots];

   glyph_type     text_to_send [$];
   placement_type placements_due [$];
   glyph_type     on_wire;
   placement_type got, want;

   int  idle_pct = 0;
   bit  calm = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  cycles = 0;
   int  glyphs_sent = 0;
   int  beats_seen = 0;
   int  moved_seen = 0;
   int  wraps = 0;
   int  bad_beats = 0;

   function automatic logic [15:0] clip16(input int v);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic void place_glyph(input glyph_type g);
      logic [11:0] idx;
      logic [15:0] x, row_y;
      int k;
      if (g.start) begin
         pen_x = '0;
         pen_y = '0;
         text_index = '0;
         word_len = '0;
         word_x0 = '0;
         word_overflow = 1'b0;
      end
      idx = text_index;
      text_index = text_index + 12'd1;

      if (g.code == CharNewline) begin
         pen_x = '0;
         pen_y = clip16(int'(pen_y) + int'(row_step));
         word_len = '0;
         word_overflow = 1'b0;
         placements_due.push_back('{idx, 16'd0, pen_y, 8'd0, 8'd0, 1'b0, 1'b1});
         return;
      end

      if (word_len == 0 && !word_overflow)
         word_x0 = pen_x;
      x = pen_x;
      // The word moves only if it does not already start the line and fits the buffer.
      if (int'(pen_x) + int'(g.gw) > int'(avail_width) && word_x0 != 0 &&
          !word_overflow && word_len < WordSlots) begin
         row_y = clip16(int'(pen_y) + int'(row_step));
         x = '0;
         for (k = 0; k < word_len; k++) begin
            placements_due.push_back('{word_buf[k].index, x, row_y, word_buf[k].w,
                                       word_buf[k].h, 1'b1, 1'b0});
            x = clip16(int'(x) + int'(word_buf[k].w));
         end
         pen_y = row_y;
         word_x0 = '0;
         wraps++;
      end

      placements_due.push_back('{idx, x, pen_y, g.gw, g.gh, 1'b0, 1'b1});
      pen_x = clip16(int'(x) + int'(g.gw));

      if (!word_overflow && word_len < WordSlots) begin
         word_buf[word_len] = '{idx, g.gw, g.gh};
         word_len++;
      end else begin
         word_overflow = 1'b1;
      end

      if (g.code inside {CharSpace, CharPeriod, CharComma, CharQuery}) begin
         word_len = '0;
         word_overflow = 1'b0;
      end
   endfunction

   // Sender: presents queued characters, with random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
         pen_x = '0;
         pen_y = '0;
         word_x0 = '0;
         text_index = '0;
         word_len = '0;
         word_overflow = 1'b0;
         avail_width = 12'd640;
         row_step = 8'd16;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrAvailWidth: avail_width = csr_data;
               CsrLineHeight: row_step = csr_data[7:0];
            endcase
         end
         if (req_tvalid && req_tready) begin
            place_glyph(on_wire);
            glyphs_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // Beat still waiting; keep it on the bus.
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (text_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(99) < idle_pct) begin
            send_gap <= $urandom_range(12);
            req_tvalid <= 1'b0;
         end else begin
            on_wire = text_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {on_wire.gh, on_wire.gw, on_wire.code};
            req_tuser <= on_wire.start;
         end
      end
   end

   // Receiver: checks each accepted placement beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[11:0], rsp_tdata[27:12], rsp_tdata[43:28], rsp_tdata[51:44],
                    rsp_tdata[59:52], rsp_tuser, rsp_tlast};
            beats_seen++;
            if (rsp_tuser === 1'b1)
               moved_seen++;
            if (placements_due.size() == 0) begin
               bad_beats++;
               if (bad_beats <= ShownErrors)
                  $display("%0t: placement beat with nothing predicted: idx=%0d x=%0d y=%0d",
                           $time, got.index, got.x, got.y);
            end else begin
               want = placements_due.pop_front();
               if (got !== want) begin
                  bad_beats++;
                  if (bad_beats <= ShownErrors) begin
                     $display("%0t: placement differs", $time);
                     $display("  expected idx=%0d x=%0d y=%0d w=%0d h=%0d moved=%b last=%b",
                              want.index, want.x, want.y, want.w, want.h, want.moved,
                              want.last);
                     $display("  actual   idx=%0d x=%0d y=%0d w=%0d h=%0d moved=%b last=%b",
                              got.index, got.x, got.y, got.w, got.h, got.moved, got.last);
                  end
               end
            end
         end
         if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) < idle_pct) begin
            stall_left <= $urandom_range(12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_glyph(input logic start, input logic [7:0] code,
                              input logic [7:0] gw, input logic [7:0] gh);
      text_to_send.push_back('{start, code, gw, gh});
   endtask

   // Mostly well-formed words of random letters, some longer than the word
   // buffer, ended by a break character or a newline; a few stray bytes mixed in.
   task automatic queue_words(input int n_items, input int wmax, input bit starts_ok);
      int made;
      int len;
      int i;
      glyph_type g;
      made = 0;
      while (made < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            g.start = starts_ok && i == 0 && $urandom_range(24) == 0;
            g.code = ($urandom_range(15) == 0) ? 8'($urandom) :
                     CharLetterA + 8'($urandom_range(25));
            g.gw = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(wmax));
            g.gh = 8'($urandom);
            text_to_send.push_back(g);
         end
         made += len;
         g.start = 1'b0;
         g.gw = 8'($urandom_range(wmax));
         g.gh = 8'($urandom);
         case ($urandom_range(9))
            0: g.code = CharNewline;
            1: g.code = CharPeriod;
            2: g.code = CharComma;
            3: g.code = CharQuery;
            9: g.code = CharLowest;
            default: g.code = CharSpace;
         endcase
         // A missing terminator lets the next word run on.
         if (g.code != CharLowest) begin
            text_to_send.push_back(g);
            made++;
         end
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (text_to_send.size() != 0 || req_tvalid || placements_due.size() != 0);
      repeat (SettleTicks) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [11:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Each phase starts only once every placement of the previous one has come back.
   task automatic new_phase(input int avail, input int lh, input int pct);
      settle();
      write_csr(CsrAvailWidth, 12'(avail));
      write_csr(CsrLineHeight, 12'(lh));
      @(negedge clock);
      idle_pct = pct;
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_pct = 20;

      // Reset widths: an empty-word wrap, a word that starts its line, a two-glyph replay.
      queue_glyph(1'b1, CharLowest, 8'd0, 8'd0);
      queue_glyph(1'b0, CharHighest, 8'd255, 8'd255);
      queue_glyph(1'b0, CharLetterA, 8'd255, 8'd1);
      queue_glyph(1'b0, CharSpace, 8'd10, 8'd2);
      queue_glyph(1'b0, CharLetterA + 8'd2, 8'd200, 8'd3);
      queue_glyph(1'b0, CharLetterA + 8'd4, 8'd255, 8'd5);
      queue_glyph(1'b0, CharLetterA + 8'd5, 8'd255, 8'd6);
      queue_glyph(1'b0, CharNewline, 8'd9, 8'd9);
      queue_glyph(1'b0, CharComma, 8'd30, 8'd0);
      queue_glyph(1'b0, CharLetterA + 8'd23, 8'd200, 8'd8);
      queue_glyph(1'b0, CharLetterA + 8'd24, 8'd200, 8'd9);
      queue_glyph(1'b0, CharLetterA + 8'd25, 8'd255, 8'd10);
      queue_glyph(1'b0, CharPeriod, 8'd1, 8'd1);
      queue_glyph(1'b0, CharQuery, 8'd2, 8'd2);

      // Zero available width still wraps words that do not start the line.
      new_phase(0, 255, 10);
      queue_glyph(1'b1, CharLetterA, 8'd1, 8'd1);
      queue_glyph(1'b0, CharSpace, 8'd3, 8'd3);
      queue_glyph(1'b0, CharLetterA + 8'd1, 8'd0, 8'd0);
      queue_glyph(1'b0, CharNewline, 8'd0, 8'd0);

      new_phase(4095, 0, 10);
      queue_glyph(1'b1, CharNewline, 8'd255, 8'd255);
      queue_glyph(1'b0, CharLetterA + 8'd16, 8'd255, 8'd255);
      queue_glyph(1'b0, 8'h7F, 8'd128, 8'd128);

      // A word longer than the buffer runs past the line end without moving;
      // the word after it then wraps on its own.
      new_phase(1000, 40, 15);
      queue_glyph(1'b1, CharLetterA, 8'd4, 8'd4);
      queue_glyph(1'b0, CharSpace, 8'd5, 8'd5);
      for (i = 0; i < 40; i++)
         queue_glyph(1'b0, CharLetterA + 8'($urandom_range(25)), 8'd30, 8'($urandom));
      queue_glyph(1'b0, CharSpace, 8'd5, 8'd5);
      queue_glyph(1'b0, CharLetterA + 8'd25, 8'd30, 8'd7);
      queue_glyph(1'b0, CharLetterA + 8'd1, 8'd30, 8'd8);
      queue_glyph(1'b0, CharPeriod, 8'd3, 8'd3);

      new_phase(200, 0, 10);
      queue_words(70, 40, 1'b0);

      new_phase(100, 20, 15);
      queue_words(55, 20, 1'b1);
      new_phase(60, 255, 0);
      queue_words(35, 12, 1'b1);
      new_phase($urandom_range(50, 400), $urandom_range(255), 25);
      queue_words(50, 40, 1'b1);
      new_phase(300, 7, 0);
      calm = 1'b1;
      queue_words(30, 30, 1'b1);

      settle();
      repeat (20) @(negedge clock);
      if (placements_due.size() != 0)
         bad_beats++;
      $display("Sent %0d characters; checked %0d placement beats, %0d of them replayed",
               glyphs_sent, beats_seen, moved_seen);
      $display("by %0d word wraps; %0d beats were wrong", wraps, bad_beats);
      if (bad_beats == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
